// ----- src/onc_pkg.sv -----
// shared types and constants of the operator, number and comment lexer
`default_nettype none

package onc_pkg;

	// defaults for the top-level parameters
	localparam int OFFSET_BITS_DEF = 24;
	localparam int QUEUE_DEPTH_DEF = 4;

	// fixed field widths of a token
	localparam int START_W = 24;
	localparam int LEN_W   = 25;

	// longest digit run that a token can report
	localparam logic [LEN_W-1:0] LEN_SAT = 25'h100_0000;

	// source characters the lexer reacts to
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	// token kinds as seen on the result port
	typedef enum logic [2:0] {
		KIND_PLUS  = 3'd0,
		KIND_DASH  = 3'd1,
		KIND_STAR  = 3'd2,
		KIND_SLASH = 3'd3,
		KIND_INT   = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
	} token_t;

	// all tokens caused by one source byte: one or two
	typedef struct packed {
		token_t tok0;
		token_t tok1;
		logic   two;
	} record_t;

endpackage

`default_nettype wire

// ----- src/onc_front.sv -----
// front end: scan state machine that turns each source byte into a token record
`default_nettype none

module onc_front import onc_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] source_byte,
	input  wire logic       is_final,
	output record_t         rec,
	output logic            rec_valid
);

	typedef enum logic [5:0] {
		M_IDLE   = 6'b000001,
		M_SLASH  = 6'b000010,
		M_LINE   = 6'b000100,
		M_BLOCK  = 6'b001000,
		M_BSTAR  = 6'b010000,
		M_NUMBER = 6'b100000
	} mode_t;

	mode_t                  mode_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [START_W-1:0]     pend_q;
	logic [LEN_W-1:0]       run_q;

	logic [START_W-1:0] pos_s;
	logic               is_dig;

	logic  ib_op_v;
	kind_t ib_kind;
	mode_t ib_mode;

	mode_t              nm;
	logic [START_W-1:0] np;
	logic [LEN_W-1:0]   nr;
	logic               use_ib;
	logic               a_v, b_v, c_v;
	token_t             a_tok, b_tok, c_tok;

	// offset of the arriving byte, shown in the token's start width
	assign pos_s  = START_W'(pos_q);
	assign is_dig = (source_byte >= CH_ZERO) && (source_byte <= CH_NINE);

	// what a byte does when seen from idle
	always_comb begin
		ib_op_v = 1'b0;
		ib_kind = KIND_PLUS;
		ib_mode = M_IDLE;
		if (source_byte == CH_PLUS) begin
			ib_op_v = 1'b1;
			ib_kind = KIND_PLUS;
		end else if (source_byte == CH_DASH) begin
			ib_op_v = 1'b1;
			ib_kind = KIND_DASH;
		end else if (source_byte == CH_STAR) begin
			ib_op_v = 1'b1;
			ib_kind = KIND_STAR;
		end else if (source_byte == CH_SLASH) begin
			ib_mode = M_SLASH;
		end else if (is_dig) begin
			ib_mode = M_NUMBER;
		end
	end

	// mode transitions and the up to three token sources
	always_comb begin
		nm          = mode_q;
		np          = pend_q;
		nr          = run_q;
		use_ib      = 1'b0;
		a_v         = 1'b0;
		a_tok.kind  = KIND_SLASH;
		a_tok.start = pend_q;
		a_tok.len   = LEN_W'(1);
		unique case (mode_q)
			M_SLASH: begin
				if (source_byte == CH_SLASH) begin
					nm = M_LINE;
				end else if (source_byte == CH_STAR) begin
					nm = M_BLOCK;
				end else begin
					a_v    = 1'b1;
					use_ib = 1'b1;
				end
			end
			M_LINE: begin
				if (source_byte == CH_NEWLINE) begin
					nm = M_IDLE;
				end
			end
			M_BLOCK: begin
				if (source_byte == CH_STAR) begin
					nm = M_BSTAR;
				end
			end
			M_BSTAR: begin
				if (source_byte == CH_SLASH) begin
					nm = M_IDLE;
				end else if (source_byte != CH_STAR) begin
					nm = M_BLOCK;
				end
			end
			M_NUMBER: begin
				if (is_dig) begin
					nr = (run_q < LEN_SAT) ? run_q + LEN_W'(1) : run_q;
				end else begin
					a_v        = 1'b1;
					a_tok.kind = KIND_INT;
					a_tok.len  = run_q;
					use_ib     = 1'b1;
				end
			end
			M_IDLE: begin
				use_ib = 1'b1;
			end
			default: begin
				use_ib = 1'b1;
			end
		endcase

		// restart from idle on this byte
		b_v         = 1'b0;
		b_tok.kind  = ib_kind;
		b_tok.start = pos_s;
		b_tok.len   = LEN_W'(1);
		if (use_ib) begin
			nm  = ib_mode;
			b_v = ib_op_v;
			if (ib_mode == M_SLASH) begin
				np = pos_s;
			end else if (ib_mode == M_NUMBER) begin
				np = pos_s;
				nr = LEN_W'(1);
			end
		end

		// final byte flushes a pending slash or digit run
		c_v         = is_final && ((nm == M_SLASH) || (nm == M_NUMBER));
		c_tok.kind  = (nm == M_SLASH) ? KIND_SLASH : KIND_INT;
		c_tok.start = np;
		c_tok.len   = (nm == M_SLASH) ? LEN_W'(1) : nr;
	end

	// pack the live tokens into one record, oldest first
	always_comb begin
		rec.tok0  = a_v ? a_tok : (b_v ? b_tok : c_tok);
		rec.tok1  = b_v ? b_tok : c_tok;
		rec.two   = a_v && (b_v || c_v);
		rec_valid = accept && (a_v || b_v || c_v);
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q  <= '0;
			pend_q <= '0;
			run_q  <= '0;
		end else if (accept) begin
			if (is_final) begin
				mode_q <= M_IDLE;
				pos_q  <= '0;
				pend_q <= '0;
				run_q  <= '0;
			end else begin
				mode_q <= nm;
				pos_q  <= pos_q + OFFSET_BITS'(1);
				pend_q <= np;
				run_q  <= nr;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_final_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_final) |=> (pos_q == '0) && (mode_q == M_IDLE))
		else $error("final byte did not restart the scan");

	a_comment_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (mode_q == M_LINE || mode_q == M_BLOCK || mode_q == M_BSTAR)
			&& !is_final) |-> !rec_valid)
		else $error("token produced inside a comment");
`endif

endmodule

`default_nettype wire

// ----- src/onc_queue.sv -----
// record queue that decouples the scanner from the token output side
`default_nettype none

module onc_queue import onc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wr,
	input  wire record_t wdata,
	output logic         full,
	input  wire logic    rd,
	output record_t      rdata,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	record_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
			end
			if (rd) begin
				rp_q <= (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && full && !rd) && !(rd && empty))
		else $error("queue written while full or read while empty");
`endif

endmodule

`default_nettype wire

// ----- src/onc_back.sv -----
// back end: output register that hands out the tokens of each record one beat at a time
`default_nettype none

module onc_back import onc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    q_empty,
	input  wire record_t q_data,
	output logic         q_rd,
	input  wire logic    pop,
	output logic         empty,
	output token_t       tok,
	output logic         last
);

	record_t cur_q;
	logic    valid_q;
	logic    sel_q;
	logic    take;
	logic    done;

	// beat bookkeeping
	assign take  = valid_q && pop;
	assign last  = !cur_q.two || sel_q;
	assign done  = !valid_q || (take && last);
	assign q_rd  = done && !q_empty;
	assign empty = !valid_q;
	assign tok   = sel_q ? cur_q.tok1 : cur_q.tok0;

	// record payload
	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_data;
		end
	end

	// output valid and token select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
			sel_q   <= 1'b0;
		end else if (done) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (take) begin
			sel_q <= 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_second_needs_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && sel_q) |-> cur_q.two)
		else $error("second token selected from a single-token record");

	a_pair_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !last) |=> (valid_q && sel_q))
		else $error("second token of a pair was lost");
`endif

endmodule

`default_nettype wire

// ----- src/operator_number_comment_lexer_unit.sv -----
// top level of the operator, number and comment lexer
//
// channel   direction  handshake              beat
// source    in         push / full            source_byte, is_final
// token     out        empty / pop            token_kind, start_offset, token_length, run_end
//
// one source byte is taken per cycle while full is low; the scanner decides each byte in that cycle
// a byte that yields two tokens hands them out one after the other on the token side, one per pop
// a token passes through the record queue and then the output register before it shows on the outputs
// full rises when QUEUE_DEPTH token records wait between scanner and output register
// arst_n clears scan state, offsets and queue at once; no clearing pass
`default_nettype none

module operator_number_comment_lexer_unit import onc_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [7:0]         source_byte,
	input  wire logic               is_final,
	output logic                    empty,
	input  wire logic               pop,
	output logic [2:0]              token_kind,
	output logic [START_W-1:0]      start_offset,
	output logic [LEN_W-1:0]        token_length,
	output logic                    run_end
);

	logic    accept;
	record_t rec;
	logic    rec_valid;
	record_t q_data;
	logic    q_empty;
	logic    q_rd;
	token_t  tok;

	assign accept = push && !full;

	// scanner
	onc_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.source_byte(source_byte),
		.is_final   (is_final),
		.rec        (rec),
		.rec_valid  (rec_valid)
	);

	// record queue
	onc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (rec_valid),
		.wdata (rec),
		.full  (full),
		.rd    (q_rd),
		.rdata (q_data),
		.empty (q_empty)
	);

	// token output
	onc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_data (q_data),
		.q_rd   (q_rd),
		.pop    (pop),
		.empty  (empty),
		.tok    (tok),
		.last   (run_end)
	);

	assign token_kind   = tok.kind;
	assign start_offset = tok.start;
	assign token_length = tok.len;

endmodule

`default_nettype wire
